@@ hdl/rlesd_pkg.sv @@
// ----------------------------------------------------------------------------
// rlesd_pkg
// Shared types and codes for the run-length indexed sprite decoder.
// ----------------------------------------------------------------------------
package rlesd_pkg;

	// input word kinds
	localparam logic [1:0] KIND_SCAN = 2'd0;
	localparam logic [1:0] KIND_PAL  = 2'd1;
	localparam logic [1:0] KIND_MAP  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_ROW_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT     = 2'd1;
	localparam logic [1:0] REG_OVR_ENABLE = 2'd2;
	localparam logic [1:0] REG_OVR_SET    = 2'd3;

	localparam int CFG_DATA_W = 13;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] data_word;
		logic [13:0] table_address;
	} in_word_t;

	typedef struct packed {
		logic        pixel_valid;
		logic [15:0] column;
		logic [11:0] row;
		logic [15:0] color;
		logic        end_of_line;
	} out_word_t;

endpackage

@@ hdl/rle_indexed_sprite_decoder.sv @@
// ----------------------------------------------------------------------------
// rle_indexed_sprite_decoder
// Parses run-length sprite scanline words and emits RGB565 pixels with
// column and row; indexed pixels go through a set map (or override set) and a palette memory.
// ----------------------------------------------------------------------------
//
//  channel  | signals                          | word
//  ---------+----------------------------------+-------------------------------
//  item     | item_valid, item_stall, item     | scanline / palette / map word
//  result   | result_valid, result_stall, result | one pixel or end of line
//  cfg      | cfg_valid, cfg_ready, cfg_index, | register write, always ready
//           | cfg_data                         |
//
// One input word per cycle while item_stall is low. Parsing is done as the word is
// accepted; a word that yields a result moves through stage 1 (map read as the
// word is accepted) and then stage 2 (palette read, the result register that
// drives the result port).
// Reset clears parse state and config; palette and map are not cleared.
// item_stall rises only when both stages hold words and the result is stalled.
// ----------------------------------------------------------------------------
module rle_indexed_sprite_decoder #(
	parameter int COLOR_SETS = 64,
	parameter int GRADATIONS = 256,
	parameter int MAX_WIDTH  = 4096
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  item_valid,
	output logic                                  item_stall,
	input  rlesd_pkg::in_word_t                   item,
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output rlesd_pkg::out_word_t                  result,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [1:0]                            cfg_index,
	input  logic [rlesd_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int PalDepth = COLOR_SETS * GRADATIONS;
	localparam int PalAw    = (PalDepth > 1) ? $clog2(PalDepth) : 1;
	localparam logic [16:0] MaxWidth = 17'(MAX_WIDTH);

	// parse phases
	localparam logic [2:0] PH_COUNT     = 3'd0;
	localparam logic [2:0] PH_SKIP      = 3'd1;
	localparam logic [2:0] PH_IDX_COUNT = 3'd2;
	localparam logic [2:0] PH_IDX_DATA  = 3'd3;
	localparam logic [2:0] PH_NRM_COUNT = 3'd4;
	localparam logic [2:0] PH_NRM_DATA  = 3'd5;

	// configuration
	logic [12:0] row_width_q;
	logic [12:0] height_q;
	logic        ovr_en_q;
	logic [5:0]  ovr_set_q;

	// parse state
	logic [2:0]  phase_q;
	logic [15:0] groups_q;
	logic [15:0] run_q;
	logic [15:0] col_q;
	logic [11:0] row_q;

	logic [2:0]  phase_n;
	logic [15:0] groups_n;
	logic [15:0] run_n;
	logic [15:0] col_n;
	logic [11:0] row_n;

	// memories
	logic [15:0] palette_mem_q [PalDepth];
	logic [5:0]  set_map_q [256];

	// stage 1
	logic        v_s1;
	logic        pv_s1;
	logic [15:0] col_s1;
	logic [11:0] row_s1;
	logic [15:0] color_s1;
	logic        eol_s1;
	logic        idx_s1;
	logic [7:0]  grad_s1;
	logic [5:0]  map_rd_s1;

	// stage 2 (result register)
	logic        v_s2;
	logic        pv_s2;
	logic [15:0] col_s2;
	logic [11:0] row_s2;
	logic [15:0] color_s2;
	logic        eol_s2;
	logic        idx_s2;
	logic        in_range_s2;
	logic [15:0] pal_rd_s2;

	logic en1, en2, accept;

	// parse outputs
	logic        res_c;
	logic        pv_c;
	logic        eol_c;
	logic        idx_c;
	logic [15:0] col_c;
	logic [11:0] row_c;

	logic [15:0] word;
	logic [16:0] width;
	logic [16:0] skip_sum;
	logic [15:0] col_inc;
	logic [15:0] run_dec;
	logic [15:0] groups_dec;
	logic [11:0] row_inc;
	logic [11:0] row_next;
	logic        drawn;
	logic        line_end;

	// palette addressing
	logic [5:0]  wr_set;
	logic [7:0]  wr_grad;
	logic        wr_ok;
	logic [16:0] wr_full;
	logic [5:0]  rd_set;
	logic        rd_ok;
	logic [16:0] rd_full;

	// ---------------- handshake ----------------
	assign en2        = !v_s2 || !result_stall;
	assign en1        = !v_s1 || en2;
	assign item_stall = !en1;
	assign accept     = item_valid && en1;
	assign cfg_ready  = 1'b1;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= 13'd4096;
			height_q    <= 13'd4096;
			ovr_en_q    <= 1'b0;
			ovr_set_q   <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				rlesd_pkg::REG_ROW_WIDTH:  row_width_q <= cfg_data;
				rlesd_pkg::REG_HEIGHT:     height_q    <= cfg_data;
				rlesd_pkg::REG_OVR_ENABLE: ovr_en_q    <= cfg_data[0];
				rlesd_pkg::REG_OVR_SET:    ovr_set_q   <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// ---------------- scanline parser ----------------
	assign word       = item.data_word;
	assign width      = ({4'd0, row_width_q} < MaxWidth) ? {4'd0, row_width_q} : MaxWidth;
	assign skip_sum   = {1'b0, col_q} + {1'b0, word};
	assign col_inc    = (col_q == 16'hFFFF) ? col_q : col_q + 16'd1;
	assign run_dec    = run_q - 16'd1;
	assign groups_dec = groups_q - 16'd1;
	assign row_inc    = row_q + 12'd1;
	// row wraps when the next row reaches the sprite height
	assign row_next   = ({1'b0, row_inc} >= height_q) ? 12'd0 : row_inc;
	assign drawn      = {1'b0, col_q} < width;

	always_comb begin
		phase_n  = phase_q;
		groups_n = groups_q;
		run_n    = run_q;
		col_n    = col_q;
		row_n    = row_q;
		res_c    = 1'b0;
		pv_c     = 1'b0;
		eol_c    = 1'b0;
		idx_c    = 1'b0;
		col_c    = '0;
		row_c    = row_q;
		line_end = 1'b0;
		if (item.kind == rlesd_pkg::KIND_SCAN) begin
			case (phase_q)
				PH_COUNT: begin
					groups_n = word;
					if (word == 16'd0) begin
						line_end = 1'b1;
						res_c    = 1'b1;
						eol_c    = 1'b1;
					end else begin
						phase_n = PH_SKIP;
					end
				end
				PH_SKIP: begin
					col_n   = skip_sum[16] ? 16'hFFFF : skip_sum[15:0];
					phase_n = PH_IDX_COUNT;
				end
				PH_IDX_COUNT: begin
					run_n   = word;
					phase_n = (word == 16'd0) ? PH_NRM_COUNT : PH_IDX_DATA;
				end
				PH_IDX_DATA: begin
					col_n = col_inc;
					run_n = run_dec;
					if (run_dec == 16'd0) begin
						phase_n = PH_NRM_COUNT;
					end
					if (drawn) begin
						res_c = 1'b1;
						pv_c  = 1'b1;
						idx_c = 1'b1;
						col_c = col_q;
					end
				end
				PH_NRM_COUNT: begin
					run_n = word;
					if (word != 16'd0) begin
						phase_n = PH_NRM_DATA;
					end else begin
						groups_n = groups_dec;
						if (groups_dec == 16'd0) begin
							line_end = 1'b1;
							res_c    = 1'b1;
							eol_c    = 1'b1;
						end else begin
							phase_n = PH_SKIP;
						end
					end
				end
				PH_NRM_DATA: begin
					col_n = col_inc;
					run_n = run_dec;
					if (run_dec == 16'd0) begin
						groups_n = groups_dec;
						if (groups_dec == 16'd0) begin
							line_end = 1'b1;
						end else begin
							phase_n = PH_SKIP;
						end
					end
					if (drawn) begin
						res_c = 1'b1;
						pv_c  = 1'b1;
						col_c = col_q;
						eol_c = line_end;
					end else if (line_end) begin
						res_c = 1'b1;
						eol_c = 1'b1;
					end
				end
				default: begin
					phase_n = PH_COUNT;
				end
			endcase
			// closing a line resets the parse and steps the row
			if (line_end) begin
				row_n    = row_next;
				col_n    = '0;
				groups_n = '0;
				run_n    = '0;
				phase_n  = PH_COUNT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_COUNT;
			groups_q <= '0;
			run_q    <= '0;
			col_q    <= '0;
			row_q    <= '0;
		end else if (accept) begin
			phase_q  <= phase_n;
			groups_q <= groups_n;
			run_q    <= run_n;
			col_q    <= col_n;
			row_q    <= row_n;
		end
	end

	// ---------------- set map ----------------
	always_ff @(posedge clk) begin
		if (accept && item.kind == rlesd_pkg::KIND_MAP && item.table_address[13:8] == 6'd0) begin
			set_map_q[item.table_address[7:0]] <= word[5:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			map_rd_s1 <= set_map_q[word[15:8]];
		end
	end

	// ---------------- stage 1 ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= accept && res_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			pv_s1    <= pv_c;
			col_s1   <= col_c;
			row_s1   <= row_c;
			color_s1 <= pv_c ? word : 16'd0;
			eol_s1   <= eol_c;
			idx_s1   <= idx_c;
			grad_s1  <= word[7:0];
		end
	end

	// ---------------- palette ----------------
	assign wr_set  = item.table_address[13:8];
	assign wr_grad = item.table_address[7:0];
	assign wr_ok   = (32'(wr_set) < COLOR_SETS) && (32'(wr_grad) < GRADATIONS);
	assign wr_full = 17'(32'(wr_set) * GRADATIONS + 32'(wr_grad));

	assign rd_set  = ovr_en_q ? ovr_set_q : map_rd_s1;
	assign rd_ok   = (32'(rd_set) < COLOR_SETS) && (32'(grad_s1) < GRADATIONS);
	assign rd_full = 17'(32'(rd_set) * GRADATIONS + 32'(grad_s1));

	always_ff @(posedge clk) begin
		if (accept && item.kind == rlesd_pkg::KIND_PAL && wr_ok) begin
			palette_mem_q[wr_full[PalAw-1:0]] <= word;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			pal_rd_s2 <= palette_mem_q[rd_full[PalAw-1:0]];
		end
	end

	// ---------------- stage 2 / result ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			pv_s2       <= pv_s1;
			col_s2      <= col_s1;
			row_s2      <= row_s1;
			color_s2    <= color_s1;
			eol_s2      <= eol_s1;
			idx_s2      <= idx_s1;
			in_range_s2 <= rd_ok;
		end
	end

	assign result_valid       = v_s2;
	assign result.pixel_valid = pv_s2;
	assign result.column      = col_s2;
	assign result.row         = row_s2;
	assign result.color       = idx_s2 ? (in_range_s2 ? pal_rd_s2 : 16'd0) : color_s2;
	assign result.end_of_line = eol_s2;

endmodule
